// File: rtl/keyed_byte_override_table_defines.svh
// ----------------------------------------------------------------------------
// keyed byte override table assertion macros
// shared concurrent assertion forms used at the end of the rtl module
// ----------------------------------------------------------------------------
`ifndef KEYED_BYTE_OVERRIDE_TABLE_DEFINES_SVH
`define KEYED_BYTE_OVERRIDE_TABLE_DEFINES_SVH

// antecedent and consequent in the same cycle
`define KBOT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kbot check failed");

// consequent in the cycle after the antecedent
`define KBOT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kbot check failed");

`endif

// File: rtl/kbot_pkg.sv
// ----------------------------------------------------------------------------
// kbot_pkg
// field widths, action codes, sequencer states and payload types of the table
// ----------------------------------------------------------------------------
`default_nettype none

package kbot_pkg;

    localparam int ACT_W  = 3;
    localparam int KIND_W = 4;
    localparam int SUB_W  = 8;
    localparam int OFF_W  = 24;
    localparam int VAL_W  = 8;
    localparam int SIDX_W = 6;
    localparam int CNT_W  = 7;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD    = 3'd0,
        ACT_REMOVE = 3'd1,
        ACT_LOOKUP = 3'd2,
        ACT_READ   = 3'd3,
        ACT_CLEAR  = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SUB_W-1:0]  sub;
        logic [OFF_W-1:0]  off;
        logic [VAL_W-1:0]  val;
    } t_entry;

    typedef struct packed {
        logic              ok;
        logic [VAL_W-1:0]  found_value;
        logic [KIND_W-1:0] slot_kind;
        logic [SUB_W-1:0]  slot_sub;
        logic [OFF_W-1:0]  slot_offset;
        logic [CNT_W-1:0]  entry_count;
        logic              any_active;
    } t_rsp;

endpackage

`default_nettype wire

// File: rtl/kbot_if.sv
// ----------------------------------------------------------------------------
// kbot channel interfaces
// valid/ready request and response channels of the keyed byte override table
// ----------------------------------------------------------------------------
`default_nettype none

interface kbot_req_if;
    logic                            valid;
    logic                            ready;
    logic [kbot_pkg::ACT_W-1:0]      action;
    logic [kbot_pkg::KIND_W-1:0]     region_class;
    logic [kbot_pkg::SUB_W-1:0]      region_sub;
    logic [kbot_pkg::OFF_W-1:0]      byte_offset;
    logic [kbot_pkg::VAL_W-1:0]      new_value;
    logic [kbot_pkg::SIDX_W-1:0]     slot_index;

    modport source (
        output valid, action, region_class, region_sub, byte_offset, new_value, slot_index,
        input  ready
    );
    modport sink (
        input  valid, action, region_class, region_sub, byte_offset, new_value, slot_index,
        output ready
    );
endinterface

interface kbot_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            ok;
    logic [kbot_pkg::VAL_W-1:0]      found_value;
    logic [kbot_pkg::KIND_W-1:0]     slot_kind;
    logic [kbot_pkg::SUB_W-1:0]      slot_sub;
    logic [kbot_pkg::OFF_W-1:0]      slot_offset;
    logic [kbot_pkg::CNT_W-1:0]      entry_count;
    logic                            any_active;

    modport source (
        output valid, ok, found_value, slot_kind, slot_sub, slot_offset, entry_count,
               any_active,
        input  ready
    );
    modport sink (
        input  valid, ok, found_value, slot_kind, slot_sub, slot_offset, entry_count,
               any_active,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/keyed_byte_override_table.sv
// add, remove and lookup scan the slot memory through its one read port, one slot a cycle
// while the response side is free, stopping at the first key match or at the last slot;
// read slot, clear and unknown actions finish without a scan; the next transaction is
// taken in the cycle after the result is registered, so transactions never overlap
// synchronous active-low reset clears the used flags, the entry count and the sequencer;
// slot keys and bytes are not cleared and are only read behind a set used flag
// ----------------------------------------------------------------------------
// keyed_byte_override_table
// fixed-slot byte override table keyed by region kind, sub-id and offset,
// searched by a sequential compare unit over a one-write-port, one-read-port slot memory
// ----------------------------------------------------------------------------
`default_nettype none

`include "keyed_byte_override_table_defines.svh"

module keyed_byte_override_table #(
    parameter int SLOT_COUNT = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    kbot_req_if.sink      i_req,
    kbot_rsp_if.source    o_rsp
);

    localparam int AW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW    = $clog2(SLOT_COUNT + 1);
    localparam int CNT_W = kbot_pkg::CNT_W;
    localparam logic [AW-1:0] LAST     = AW'(SLOT_COUNT - 1);
    localparam logic [AW:0]   SCAN_END = (AW + 1)'(SLOT_COUNT);

    kbot_pkg::t_state                r_state, n_state;
    logic [kbot_pkg::ACT_W-1:0]      r_act, n_act;
    logic [kbot_pkg::KIND_W-1:0]     r_kind, n_kind;
    logic [kbot_pkg::SUB_W-1:0]      r_sub, n_sub;
    logic [kbot_pkg::OFF_W-1:0]      r_off, n_off;
    logic [kbot_pkg::VAL_W-1:0]      r_val, n_val;
    logic [AW:0]                     r_scan, n_scan;
    logic                            r_cmp_vld, n_cmp_vld;
    logic [AW-1:0]                   r_cmp_addr, n_cmp_addr;
    logic                            r_cmp_used, n_cmp_used;
    logic                            r_free_found, n_free_found;
    logic [AW-1:0]                   r_free_addr, n_free_addr;
    logic                            r_sidx_ok, n_sidx_ok;
    logic [SLOT_COUNT-1:0]           r_used, n_used;
    logic [CW-1:0]                   r_count, n_count;
    logic                            r_out_vld, n_out_vld;
    kbot_pkg::t_rsp                  r_out, n_out;

    kbot_pkg::t_entry                r_mem [SLOT_COUNT];
    kbot_pkg::t_entry                r_rd_data;

    logic                            accept;
    logic                            out_free;
    logic                            rd_en;
    logic [AW-1:0]                   rd_addr;
    logic                            issue;
    logic                            key_match;
    logic                            free_here;
    logic                            scan_last;
    logic                            finish;
    logic                            free_any;
    logic [AW-1:0]                   free_sel;
    logic                            mem_we;
    logic [AW-1:0]                   mem_waddr;
    kbot_pkg::t_entry                mem_wdata;
    logic                            out_load;
    kbot_pkg::t_rsp                  rsp;
    logic                            key_act;

    assign i_req.ready = (r_state == kbot_pkg::ST_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign out_free    = !r_out_vld || o_rsp.ready;

    // the read register holds while a finished result waits for the response side
    assign rd_en   = (r_state == kbot_pkg::ST_IDLE) || out_free;
    assign rd_addr = (r_state == kbot_pkg::ST_IDLE) ? AW'(i_req.slot_index) : r_scan[AW-1:0];
    assign issue   = (r_scan < SCAN_END);

    // compare stage works on the slot held in the registered read data
    assign key_match = r_cmp_vld && r_cmp_used &&
                       (r_rd_data.kind == r_kind) &&
                       (r_rd_data.sub == r_sub) &&
                       (r_rd_data.off == r_off);
    assign free_here = r_cmp_vld && !r_cmp_used;
    assign scan_last = r_cmp_vld && (r_cmp_addr == LAST);
    assign finish    = key_match || scan_last;
    assign free_any  = r_free_found || free_here;
    assign free_sel  = r_free_found ? r_free_addr : r_cmp_addr;

    assign mem_wdata.kind = r_kind;
    assign mem_wdata.sub  = r_sub;
    assign mem_wdata.off  = r_off;
    assign mem_wdata.val  = r_val;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            kbot_pkg::ST_IDLE: begin
                if (accept) begin
                    case (i_req.action)
                        kbot_pkg::ACT_ADD,
                        kbot_pkg::ACT_REMOVE,
                        kbot_pkg::ACT_LOOKUP: n_state = kbot_pkg::ST_SCAN;
                        kbot_pkg::ACT_READ:   n_state = kbot_pkg::ST_READ;
                        default:              n_state = kbot_pkg::ST_FIN;
                    endcase
                end
            end
            kbot_pkg::ST_SCAN: begin
                if (out_free && finish) begin
                    n_state = kbot_pkg::ST_IDLE;
                end
            end
            kbot_pkg::ST_READ,
            kbot_pkg::ST_FIN: begin
                if (out_free) begin
                    n_state = kbot_pkg::ST_IDLE;
                end
            end
            default: n_state = kbot_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_act        = r_act;
        n_kind       = r_kind;
        n_sub        = r_sub;
        n_off        = r_off;
        n_val        = r_val;
        n_scan       = r_scan;
        n_cmp_vld    = r_cmp_vld;
        n_cmp_addr   = r_cmp_addr;
        n_cmp_used   = r_cmp_used;
        n_free_found = r_free_found;
        n_free_addr  = r_free_addr;
        n_sidx_ok    = r_sidx_ok;
        n_used       = r_used;
        n_count      = r_count;
        mem_we       = 1'b0;
        mem_waddr    = free_sel;
        out_load     = 1'b0;
        rsp          = '0;
        case (r_state)
            kbot_pkg::ST_IDLE: begin
                if (accept) begin
                    n_act        = i_req.action;
                    n_kind       = i_req.region_class;
                    n_sub        = i_req.region_sub;
                    n_off        = i_req.byte_offset;
                    n_val        = i_req.new_value;
                    n_scan       = '0;
                    n_cmp_vld    = 1'b0;
                    n_free_found = 1'b0;
                    n_cmp_used   = r_used[rd_addr];
                    n_sidx_ok    = (32'(i_req.slot_index) < SLOT_COUNT);
                    if (i_req.action == kbot_pkg::ACT_CLEAR) begin
                        n_used  = '0;
                        n_count = '0;
                    end
                end
            end
            kbot_pkg::ST_SCAN: begin
                if (out_free) begin
                    n_scan     = issue ? (r_scan + (AW + 1)'(1)) : r_scan;
                    n_cmp_vld  = issue;
                    n_cmp_addr = rd_addr;
                    n_cmp_used = r_used[rd_addr];
                    if (free_here && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_addr  = r_cmp_addr;
                    end
                    if (finish) begin
                        out_load = 1'b1;
                        case (r_act)
                            kbot_pkg::ACT_ADD: begin
                                if (key_match) begin
                                    mem_we    = 1'b1;
                                    mem_waddr = r_cmp_addr;
                                    rsp.ok    = 1'b1;
                                end else if (free_any) begin
                                    mem_we           = 1'b1;
                                    mem_waddr        = free_sel;
                                    n_used[free_sel] = 1'b1;
                                    n_count          = r_count + CW'(1);
                                    rsp.ok           = 1'b1;
                                end
                            end
                            kbot_pkg::ACT_REMOVE: begin
                                if (key_match) begin
                                    n_used[r_cmp_addr] = 1'b0;
                                    if (r_count != '0) begin
                                        n_count = r_count - CW'(1);
                                    end
                                    rsp.ok = 1'b1;
                                end
                            end
                            kbot_pkg::ACT_LOOKUP: begin
                                if (key_match) begin
                                    rsp.ok          = 1'b1;
                                    rsp.found_value = r_rd_data.val;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            kbot_pkg::ST_READ: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (r_sidx_ok && r_cmp_used) begin
                        rsp.ok          = 1'b1;
                        rsp.found_value = r_rd_data.val;
                        rsp.slot_kind   = r_rd_data.kind;
                        rsp.slot_sub    = r_rd_data.sub;
                        rsp.slot_offset = r_rd_data.off;
                    end
                end
            end
            kbot_pkg::ST_FIN: begin
                if (out_free) begin
                    out_load = 1'b1;
                    rsp.ok   = (r_act == kbot_pkg::ACT_CLEAR);
                end
            end
            default: ;
        endcase
        rsp.entry_count = CNT_W'(n_count);
        rsp.any_active  = (n_count != '0);
        n_out           = out_load ? rsp : r_out;
        n_out_vld       = out_load ? 1'b1 : (o_rsp.ready ? 1'b0 : r_out_vld);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= kbot_pkg::ST_IDLE;
            r_cmp_vld    <= 1'b0;
            r_free_found <= 1'b0;
            r_used       <= '0;
            r_count      <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cmp_vld    <= n_cmp_vld;
            r_free_found <= n_free_found;
            r_used       <= n_used;
            r_count      <= n_count;
            r_out_vld    <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act       <= n_act;
        r_kind      <= n_kind;
        r_sub       <= n_sub;
        r_off       <= n_off;
        r_val       <= n_val;
        r_scan      <= n_scan;
        r_cmp_addr  <= n_cmp_addr;
        r_cmp_used  <= n_cmp_used;
        r_free_addr <= n_free_addr;
        r_sidx_ok   <= n_sidx_ok;
        r_out       <= n_out;
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.ok          = r_out.ok;
    assign o_rsp.found_value = r_out.found_value;
    assign o_rsp.slot_kind   = r_out.slot_kind;
    assign o_rsp.slot_sub    = r_out.slot_sub;
    assign o_rsp.slot_offset = r_out.slot_offset;
    assign o_rsp.entry_count = r_out.entry_count;
    assign o_rsp.any_active  = r_out.any_active;

    // keyed actions go through the scan
    assign key_act = accept && (i_req.action == kbot_pkg::ACT_ADD ||
                                i_req.action == kbot_pkg::ACT_REMOVE ||
                                i_req.action == kbot_pkg::ACT_LOOKUP);

    `KBOT_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, 32'(r_count) <= SLOT_COUNT)
    `KBOT_ASSERT_SAME(a_count_matches_used, i_clk, i_rst_n, 1'b1, $countones(r_used) == 32'(r_count))
    `KBOT_ASSERT_NEXT(a_key_action_scans, i_clk, i_rst_n, key_act, r_state == kbot_pkg::ST_SCAN)
    `KBOT_ASSERT_SAME(a_active_flag, i_clk, i_rst_n, r_out_vld && (r_out.entry_count != '0), r_out.any_active)

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// drives add, remove, lookup, slot read, clear and unknown action transactions into the
// keyed byte override table, predicts responses from a shadow copy of the slots or takes
// typed ones, and compares the responses in order, with random stalls on both channels
// ----------------------------------------------------------------------------
module tb_top;

    localparam int SLOT_COUNT  = 64;
    localparam int IDLE_PCT    = 21;
    localparam int KEY_POOL    = 96;
    localparam int DIRECTED_N  = 24;
    localparam int RANDOM_N    = 150;
    localparam int REPORT_MAX  = 10;
    localparam int DRAIN_WAIT  = SLOT_COUNT + 8;
    localparam int LIMIT       = 400000;
    localparam int ACT_LAST    = (1 << kbot_pkg::ACT_W) - 1;

    typedef struct packed {
        logic [kbot_pkg::KIND_W-1:0] kind;
        logic [kbot_pkg::SUB_W-1:0]  sub;
        logic [kbot_pkg::OFF_W-1:0]  off;
    } t_key;

    typedef struct packed {
        logic [kbot_pkg::ACT_W-1:0]  action;
        t_key                        key;
        logic [kbot_pkg::VAL_W-1:0]  val;
        logic [kbot_pkg::SIDX_W-1:0] sidx;
    } t_cmd;

    typedef struct {
        t_cmd           cmd;
        bit             typed;
        kbot_pkg::t_rsp want;
    } t_row;

    localparam kbot_pkg::t_rsp RSP_ZERO = '0;

    logic i_clk;
    logic i_rst_n;

    kbot_req_if req_if ();
    kbot_rsp_if rsp_if ();

    keyed_byte_override_table #(
        .SLOT_COUNT(SLOT_COUNT)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_rsp  (rsp_if.source)
    );

    // shadow copy of the slot table
    bit                          tbl_used [SLOT_COUNT];
    logic [kbot_pkg::KIND_W-1:0] tbl_kind [SLOT_COUNT];
    logic [kbot_pkg::SUB_W-1:0]  tbl_sub  [SLOT_COUNT];
    logic [kbot_pkg::OFF_W-1:0]  tbl_off  [SLOT_COUNT];
    logic [kbot_pkg::VAL_W-1:0]  tbl_byte [SLOT_COUNT];
    int                          tbl_count;

    kbot_pkg::t_rsp pending_rsp_q [$];
    t_key           key_pool [KEY_POOL];
    t_key           filled_keys [$];
    t_row           directed_rows [DIRECTED_N];
    bit             quiet_run = 1'b0;
    int             fail_count = 0;
    int unsigned    cycles = 0;
    kbot_pkg::t_rsp got_rsp;
    kbot_pkg::t_rsp want_rsp;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic void empty_table();
        for (int i = 0; i < SLOT_COUNT; i++) begin
            tbl_used[i] = 1'b0;
            tbl_kind[i] = '0;
            tbl_sub[i]  = '0;
            tbl_off[i]  = '0;
            tbl_byte[i] = '0;
        end
        tbl_count = 0;
    endfunction

    function automatic int find_key(t_key k);
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (tbl_used[i] && tbl_kind[i] == k.kind && tbl_sub[i] == k.sub &&
                tbl_off[i] == k.off)
                return i;
        end
        return SLOT_COUNT;
    endfunction

    // applies one transaction to the shadow table and returns its response
    function automatic kbot_pkg::t_rsp apply_to_table(t_cmd c);
        kbot_pkg::t_rsp r;
        int             hit;
        int             free_slot;
        r = '0;
        case (c.action)
            kbot_pkg::ACT_ADD: begin
                hit = find_key(c.key);
                if (hit < SLOT_COUNT) begin
                    tbl_byte[hit] = c.val;
                    r.ok = 1'b1;
                end else begin
                    free_slot = SLOT_COUNT;
                    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
                        if (!tbl_used[i])
                            free_slot = i;
                    end
                    // table full leaves everything as it was
                    if (free_slot < SLOT_COUNT) begin
                        tbl_kind[free_slot] = c.key.kind;
                        tbl_sub[free_slot]  = c.key.sub;
                        tbl_off[free_slot]  = c.key.off;
                        tbl_byte[free_slot] = c.val;
                        tbl_used[free_slot] = 1'b1;
                        tbl_count++;
                        r.ok = 1'b1;
                    end
                end
            end
            kbot_pkg::ACT_REMOVE: begin
                hit = find_key(c.key);
                if (hit < SLOT_COUNT) begin
                    tbl_used[hit] = 1'b0;
                    if (tbl_count > 0)
                        tbl_count--;
                    r.ok = 1'b1;
                end
            end
            kbot_pkg::ACT_LOOKUP: begin
                hit = find_key(c.key);
                if (hit < SLOT_COUNT) begin
                    r.ok          = 1'b1;
                    r.found_value = tbl_byte[hit];
                end
            end
            kbot_pkg::ACT_READ: begin
                if (int'(c.sidx) < SLOT_COUNT && tbl_used[c.sidx]) begin
                    r.ok          = 1'b1;
                    r.found_value = tbl_byte[c.sidx];
                    r.slot_kind   = tbl_kind[c.sidx];
                    r.slot_sub    = tbl_sub[c.sidx];
                    r.slot_offset = tbl_off[c.sidx];
                end
            end
            kbot_pkg::ACT_CLEAR: begin
                empty_table();
                r.ok = 1'b1;
            end
            default: begin
            end
        endcase
        r.entry_count = kbot_pkg::CNT_W'(tbl_count);
        r.any_active  = (tbl_count > 0);
        return r;
    endfunction

    function automatic t_key random_key();
        t_key k;
        k.kind = kbot_pkg::KIND_W'($urandom);
        k.sub  = kbot_pkg::SUB_W'($urandom);
        k.off  = kbot_pkg::OFF_W'($urandom);
        return k;
    endfunction

    function automatic t_cmd random_cmd();
        t_cmd c;
        int   roll;
        roll   = $urandom_range(0, 99);
        c.key  = ($urandom_range(0, 9) == 0) ? random_key()
                                             : key_pool[$urandom_range(0, KEY_POOL - 1)];
        c.val  = kbot_pkg::VAL_W'($urandom);
        // low slots are the ones usually occupied
        c.sidx = ($urandom_range(0, 1) == 0) ? kbot_pkg::SIDX_W'($urandom_range(0, 15))
                                             : kbot_pkg::SIDX_W'($urandom);
        if (roll < 40)
            c.action = kbot_pkg::ACT_ADD;
        else if (roll < 55)
            c.action = kbot_pkg::ACT_REMOVE;
        else if (roll < 75)
            c.action = kbot_pkg::ACT_LOOKUP;
        else if (roll < 92)
            c.action = kbot_pkg::ACT_READ;
        else if (roll < 95)
            c.action = kbot_pkg::ACT_CLEAR;
        else
            c.action = kbot_pkg::ACT_W'($urandom_range(int'(kbot_pkg::ACT_CLEAR) + 1,
                                                       ACT_LAST));
        return c;
    endfunction

    function automatic string rsp_text(kbot_pkg::t_rsp r);
        return $sformatf("ok=%0d val=%02h kind=%h sub=%02h off=%06h cnt=%0d act=%0d",
                         r.ok, r.found_value, r.slot_kind, r.slot_sub, r.slot_offset,
                         r.entry_count, r.any_active);
    endfunction

    function automatic void report_failure(string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("%0t: %s", $realtime, msg);
    endfunction

    task automatic send_cmd(input t_cmd c, input bit typed, input kbot_pkg::t_rsp typed_rsp);
        kbot_pkg::t_rsp predicted;
        while (!quiet_run && $urandom_range(0, 99) < IDLE_PCT) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.action       <= c.action;
        req_if.region_class <= c.key.kind;
        req_if.region_sub   <= c.key.sub;
        req_if.byte_offset  <= c.key.off;
        req_if.new_value    <= c.val;
        req_if.slot_index   <= c.sidx;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        predicted = apply_to_table(c);
        pending_rsp_q.push_back(typed ? typed_rsp : predicted);
    endtask

    // response side: random back-pressure and in-order compare
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= quiet_run || ($urandom_range(0, 99) >= IDLE_PCT);
            if (rsp_if.valid && rsp_if.ready) begin
                got_rsp = '{rsp_if.ok, rsp_if.found_value, rsp_if.slot_kind,
                            rsp_if.slot_sub, rsp_if.slot_offset, rsp_if.entry_count,
                            rsp_if.any_active};
                if (pending_rsp_q.size() == 0) begin
                    report_failure({"unexpected response ", rsp_text(got_rsp)});
                end else begin
                    want_rsp = pending_rsp_q.pop_front();
                    if (got_rsp.ok !== want_rsp.ok ||
                        got_rsp.found_value !== want_rsp.found_value ||
                        got_rsp.slot_kind !== want_rsp.slot_kind ||
                        got_rsp.slot_sub !== want_rsp.slot_sub ||
                        got_rsp.slot_offset !== want_rsp.slot_offset ||
                        got_rsp.entry_count !== want_rsp.entry_count ||
                        got_rsp.any_active !== want_rsp.any_active)
                        report_failure({"mismatch exp ", rsp_text(want_rsp),
                                        " got ", rsp_text(got_rsp)});
                end
            end
        end
    end

    initial begin
        t_cmd c;

        i_rst_n             <= 1'b0;
        req_if.valid        <= 1'b0;
        req_if.action       <= '0;
        req_if.region_class <= '0;
        req_if.region_sub   <= '0;
        req_if.byte_offset  <= '0;
        req_if.new_value    <= '0;
        req_if.slot_index   <= '0;

        empty_table();
        for (int i = 0; i < KEY_POOL; i++)
            key_pool[i] = random_key();

        // typed responses only where they follow directly from the table contents
        directed_rows = '{
            '{'{kbot_pkg::ACT_LOOKUP, '{4'hF, 8'hFF, 24'hFFFFFF}, 8'h00, 6'd0}, 1'b1,
              RSP_ZERO},
            '{'{kbot_pkg::ACT_READ,   '{4'h0, 8'h00, 24'h000000}, 8'h00, 6'd0}, 1'b1,
              RSP_ZERO},
            '{'{kbot_pkg::ACT_REMOVE, '{4'hF, 8'hFF, 24'hFFFFFF}, 8'h00, 6'd0}, 1'b1,
              RSP_ZERO},
            '{'{kbot_pkg::ACT_ADD,    '{4'hF, 8'hFF, 24'hFFFFFF}, 8'hFF, 6'd0}, 1'b1,
              '{1'b1, 8'h00, 4'h0, 8'h00, 24'h000000, 7'd1, 1'b1}},
            '{'{kbot_pkg::ACT_ADD,    '{4'h0, 8'h00, 24'h000000}, 8'h00, 6'd0}, 1'b1,
              '{1'b1, 8'h00, 4'h0, 8'h00, 24'h000000, 7'd2, 1'b1}},
            '{'{kbot_pkg::ACT_LOOKUP, '{4'hF, 8'hFF, 24'hFFFFFF}, 8'h00, 6'd0}, 1'b1,
              '{1'b1, 8'hFF, 4'h0, 8'h00, 24'h000000, 7'd2, 1'b1}},
            '{'{kbot_pkg::ACT_READ,   '{4'h0, 8'h00, 24'h000000}, 8'h00, 6'd0}, 1'b1,
              '{1'b1, 8'hFF, 4'hF, 8'hFF, 24'hFFFFFF, 7'd2, 1'b1}},
            '{'{kbot_pkg::ACT_READ,   '{4'h0, 8'h00, 24'h000000}, 8'h00, 6'd1}, 1'b0,
              RSP_ZERO},
            '{'{kbot_pkg::ACT_ADD,    '{4'hF, 8'hFF, 24'hFFFFFF}, 8'h5A, 6'd0}, 1'b0,
              RSP_ZERO},
            '{'{kbot_pkg::ACT_LOOKUP, '{4'hF, 8'hFF, 24'hFFFFFE}, 8'h00, 6'd0}, 1'b0,
              RSP_ZERO},
            '{'{kbot_pkg::ACT_LOOKUP, '{4'hE, 8'hFF, 24'hFFFFFF}, 8'h00, 6'd0}, 1'b0,
              RSP_ZERO},
            '{'{kbot_pkg::ACT_ADD,    '{4'h5, 8'hA5, 24'h5A5A5A}, 8'hA5, 6'd0}, 1'b0,
              RSP_ZERO},
            '{'{kbot_pkg::ACT_REMOVE, '{4'hF, 8'hFF, 24'hFFFFFF}, 8'h00, 6'd0}, 1'b0,
              RSP_ZERO},
            '{'{kbot_pkg::ACT_READ,   '{4'h0, 8'h00, 24'h000000}, 8'h00, 6'd0}, 1'b0,
              RSP_ZERO},
            '{'{kbot_pkg::ACT_ADD,    '{4'hA, 8'h5A, 24'hA5A5A5}, 8'h3C, 6'd0}, 1'b0,
              RSP_ZERO},
            '{'{kbot_pkg::ACT_READ,   '{4'h0, 8'h00, 24'h000000}, 8'h00, 6'd0}, 1'b0,
              RSP_ZERO},
            '{'{kbot_pkg::ACT_READ,   '{4'h0, 8'h00, 24'h000000}, 8'h00, 6'd63}, 1'b0,
              RSP_ZERO},
            '{'{3'(int'(kbot_pkg::ACT_CLEAR) + 1), '{4'h5, 8'hA5, 24'h5A5A5A}, 8'h11, 6'd2},
              1'b0, RSP_ZERO},
            '{'{3'(int'(kbot_pkg::ACT_CLEAR) + 2), '{4'h0, 8'h00, 24'h000000}, 8'h00, 6'd0},
              1'b0, RSP_ZERO},
            '{'{3'(ACT_LAST), '{4'hF, 8'hFF, 24'hFFFFFF}, 8'hFF, 6'd63}, 1'b0, RSP_ZERO},
            '{'{kbot_pkg::ACT_REMOVE, '{4'h0, 8'h00, 24'h000000}, 8'h00, 6'd0}, 1'b0,
              RSP_ZERO},
            '{'{kbot_pkg::ACT_CLEAR,  '{4'h0, 8'h00, 24'h000000}, 8'h00, 6'd0}, 1'b1,
              '{1'b1, 8'h00, 4'h0, 8'h00, 24'h000000, 7'd0, 1'b0}},
            '{'{kbot_pkg::ACT_LOOKUP, '{4'hA, 8'h5A, 24'hA5A5A5}, 8'h00, 6'd0}, 1'b1,
              RSP_ZERO},
            '{'{kbot_pkg::ACT_READ,   '{4'h0, 8'h00, 24'h000000}, 8'h00, 6'd2}, 1'b1,
              RSP_ZERO}
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r])
            send_cmd(directed_rows[r].cmd, directed_rows[r].typed, directed_rows[r].want);

        for (int n = 0; n < RANDOM_N; n++)
            send_cmd(random_cmd(), 1'b0, RSP_ZERO);

        // fill the table past its size with no idling, then work on a full table
        quiet_run = 1'b1;
        c         = '0;
        c.action  = kbot_pkg::ACT_CLEAR;
        send_cmd(c, 1'b0, RSP_ZERO);
        filled_keys.delete();
        for (int n = 0; n < SLOT_COUNT + 8; n++) begin
            c.action = kbot_pkg::ACT_ADD;
            c.key    = random_key();
            c.val    = kbot_pkg::VAL_W'($urandom);
            c.sidx   = kbot_pkg::SIDX_W'($urandom);
            filled_keys.push_back(c.key);
            send_cmd(c, 1'b0, RSP_ZERO);
            if (n % 4 == 3) begin
                c.action = ($urandom_range(0, 1) == 0) ? kbot_pkg::ACT_LOOKUP
                                                       : kbot_pkg::ACT_READ;
                c.key    = filled_keys[$urandom_range(0, filled_keys.size() - 1)];
                send_cmd(c, 1'b0, RSP_ZERO);
            end
        end
        quiet_run = 1'b0;
        for (int n = 0; n < 24; n++) begin
            case (n % 3)
                0:       c.action = kbot_pkg::ACT_ADD;
                1:       c.action = kbot_pkg::ACT_LOOKUP;
                default: c.action = kbot_pkg::ACT_READ;
            endcase
            c.key  = filled_keys[$urandom_range(0, SLOT_COUNT - 1)];
            c.val  = kbot_pkg::VAL_W'($urandom);
            c.sidx = kbot_pkg::SIDX_W'($urandom);
            send_cmd(c, 1'b0, RSP_ZERO);
        end
        for (int n = 0; n < 6; n++) begin
            c.action = kbot_pkg::ACT_REMOVE;
            c.key    = filled_keys[$urandom_range(0, SLOT_COUNT - 1)];
            send_cmd(c, 1'b0, RSP_ZERO);
            c.action = kbot_pkg::ACT_ADD;
            c.key    = random_key();
            c.val    = kbot_pkg::VAL_W'($urandom);
            send_cmd(c, 1'b0, RSP_ZERO);
            c.key    = random_key();
            send_cmd(c, 1'b0, RSP_ZERO);
        end

        for (int n = 0; n < RANDOM_N; n++)
            send_cmd(random_cmd(), 1'b0, RSP_ZERO);

        req_if.valid <= 1'b0;
        while (pending_rsp_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: keyed_byte_override_table.f
+incdir+rtl
rtl/kbot_pkg.sv
rtl/kbot_if.sv
rtl/keyed_byte_override_table.sv
sim/tb_top.sv
